// ----- design/circ_pkg.sv -----
// Shared payload types and fixed widths for the circumcircle block.
package circ_pkg;

   localparam int COORD_WIDTH = 32;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] x1;
      logic signed [COORD_WIDTH-1:0] y1;
      logic signed [COORD_WIDTH-1:0] x2;
      logic signed [COORD_WIDTH-1:0] y2;
      logic signed [COORD_WIDTH-1:0] x3;
      logic signed [COORD_WIDTH-1:0] y3;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] center_x;
      logic signed [COORD_WIDTH-1:0] center_y;
      logic        [COORD_WIDTH-1:0] radius;
      logic                          collinear;
      logic                          overflow;
   } rsp_type;

endpackage

// ----- design/circ_div.sv -----
// Pipelined restoring divider: two numerators over one shared denominator, rounded and saturated.
module circ_div #(
   parameter int NW  = 101,
   parameter int DNW = 68,
   parameter int QW  = 32,
   parameter int SBW = 65
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  logic [DNW-1:0]        in_den,
   input  logic [NW-1:0]         in_num0,
   input  logic [NW-1:0]         in_num1,
   input  logic                  in_neg0,
   input  logic                  in_neg1,
   input  logic [SBW-1:0]        in_sb,
   output logic                  out_valid,
   output logic signed [QW-1:0]  out_q0,
   output logic signed [QW-1:0]  out_q1,
   output logic                  out_ovf0,
   output logic                  out_ovf1,
   output logic [SBW-1:0]        out_sb
);

   localparam int CW = (NW > DNW + QW) ? NW : DNW + QW;

   typedef struct packed {
      logic [CW-1:0] rem;
      logic [QW-1:0] quo;
      logic          sat;
      logic          neg;
   } lane_type;

   typedef struct packed {
      logic [QW:0] q;
      logic        sat;
      logic        neg;
   } rnd_type;

   typedef struct packed {
      logic signed [QW-1:0] q;
      logic                 ovf;
   } res_type;

   lane_type       l0_in [0:QW];
   lane_type       l0_ff [0:QW];
   lane_type       l1_in [0:QW];
   lane_type       l1_ff [0:QW];
   logic [DNW-1:0] den_in [0:QW];
   logic [DNW-1:0] den_ff [0:QW];
   logic [SBW-1:0] sb_in [0:QW];
   logic [SBW-1:0] sb_ff [0:QW];
   logic [QW:0]    vld_in;
   logic [QW:0]    vld_ff;

   rnd_type        r0_in, r0_ff, r1_in, r1_ff;
   logic [SBW-1:0] rsb_ff;
   logic           rvld_ff;

   res_type        o0_in, o0_ff, o1_in, o1_ff;
   logic [SBW-1:0] osb_ff;
   logic           ovld_ff;

   // A quotient of 2^QW or more cannot fit, so it is caught before the bit steps.
   function automatic lane_type lane_start(logic [NW-1:0] num, logic [DNW-1:0] den,
                                           logic neg);
      lane_type l;
      l.rem = CW'(num);
      l.quo = '0;
      l.neg = neg;
      l.sat = CW'(num) >= (CW'(den) << QW);
      return l;
   endfunction

   function automatic lane_type lane_step(lane_type l, logic [DNW-1:0] den, int k);
      lane_type    r;
      logic [CW:0] t;
      r = l;
      t = {1'b0, l.rem} - ((CW + 1)'(den) << k);
      if (!t[CW]) begin
         r.rem = t[CW-1:0];
         r.quo = l.quo | (QW'(1) << k);
      end
      return r;
   endfunction

   function automatic rnd_type lane_round(lane_type l, logic [DNW-1:0] den);
      rnd_type r;
      r.sat = l.sat;
      r.neg = l.neg;
      r.q   = {1'b0, l.quo} + (QW + 1)'(({l.rem, 1'b0}) >= (CW + 1)'(den));
      return r;
   endfunction

   function automatic res_type lane_finish(rnd_type r);
      res_type     o;
      logic [QW:0] lim;
      lim   = r.neg ? ((QW + 1)'(1) << (QW - 1)) : (((QW + 1)'(1) << (QW - 1)) - 1'b1);
      o.ovf = r.sat || (r.q > lim);
      if (o.ovf) begin
         o.q = r.neg ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
      end else begin
         o.q = r.neg ? -$signed(r.q[QW-1:0]) : $signed(r.q[QW-1:0]);
      end
      return o;
   endfunction

   always_comb begin
      l0_in[0]  = lane_start(in_num0, in_den, in_neg0);
      l1_in[0]  = lane_start(in_num1, in_den, in_neg1);
      den_in[0] = in_den;
      sb_in[0]  = in_sb;
      vld_in[0] = in_valid;
      for (int j = 1; j <= QW; j++) begin
         l0_in[j]  = lane_step(l0_ff[j-1], den_ff[j-1], QW - j);
         l1_in[j]  = lane_step(l1_ff[j-1], den_ff[j-1], QW - j);
         den_in[j] = den_ff[j-1];
         sb_in[j]  = sb_ff[j-1];
         vld_in[j] = vld_ff[j-1];
      end
      r0_in = lane_round(l0_ff[QW], den_ff[QW]);
      r1_in = lane_round(l1_ff[QW], den_ff[QW]);
      o0_in = lane_finish(r0_ff);
      o1_in = lane_finish(r1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= vld_in;
         rvld_ff <= vld_ff[QW];
         ovld_ff <= rvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j <= QW; j++) begin
            l0_ff[j]  <= l0_in[j];
            l1_ff[j]  <= l1_in[j];
            den_ff[j] <= den_in[j];
            sb_ff[j]  <= sb_in[j];
         end
         r0_ff   <= r0_in;
         r1_ff   <= r1_in;
         rsb_ff  <= sb_ff[QW];
         o0_ff   <= o0_in;
         o1_ff   <= o1_in;
         osb_ff  <= rsb_ff;
      end
   end

   assign out_valid = ovld_ff;
   assign out_q0    = o0_ff.q;
   assign out_q1    = o1_ff.q;
   assign out_ovf0  = o0_ff.ovf;
   assign out_ovf1  = o1_ff.ovf;
   assign out_sb    = osb_ff;

`ifndef ASSERT_OFF
   // The remainder must end below the denominator unless the lane saturated early.
   property p_rem_below_den;
      @(posedge clock) disable iff (reset)
         vld_ff[QW] && !l0_ff[QW].sat |-> l0_ff[QW].rem < CW'(den_ff[QW]);
   endproperty
   a_rem_below_den: assert property (p_rem_below_den)
      else $error("divider remainder not below denominator");
`endif

endmodule

// ----- design/circ_sqrt.sv -----
// Pipelined restoring square root, one result bit per stage, rounded and saturated.
module circ_sqrt #(
   parameter int SW  = 66,
   parameter int RW  = 33,
   parameter int OW  = 32,
   parameter int SBW = 66
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           en,
   input  logic           in_valid,
   input  logic [SW-1:0]  in_sq,
   input  logic [SBW-1:0] in_sb,
   output logic           out_valid,
   output logic [OW-1:0]  out_root,
   output logic           out_ovf,
   output logic [SBW-1:0] out_sb
);

   localparam int TW = ((SW > 2 * RW) ? SW : 2 * RW) + 1;

   typedef struct packed {
      logic [TW-1:0] rem;
      logic [RW-1:0] root;
   } lane_type;

   typedef struct packed {
      logic [RW-1:0] root;
      logic          inc;
   } rnd_type;

   lane_type       l_in [1:RW];
   lane_type       l_ff [1:RW];
   logic [SBW-1:0] sb_in [1:RW];
   logic [SBW-1:0] sb_ff [1:RW];
   logic [RW:1]    vld_in;
   logic [RW:1]    vld_ff;

   rnd_type        rd_in, rd_ff;
   logic [SBW-1:0] rsb_ff;
   logic           rvld_ff;

   logic [RW:0]    sum;
   logic [OW-1:0]  root_in, root_ff;
   logic           ovf_in, ovf_ff;
   logic [SBW-1:0] osb_ff;
   logic           ovld_ff;

   // Setting bit i adds 2*root*2^i + 2^(2i) to the square.
   function automatic lane_type lane_step(lane_type l, int i);
      lane_type      r;
      logic [TW-1:0] trial;
      r     = l;
      trial = (TW'(l.root) << (i + 1)) + (TW'(1) << (2 * i));
      if (l.rem >= trial) begin
         r.rem  = l.rem - trial;
         r.root = l.root | (RW'(1) << i);
      end
      return r;
   endfunction

   always_comb begin
      lane_type first;
      first.rem  = TW'(in_sq);
      first.root = '0;
      l_in[1]   = lane_step(first, RW - 1);
      sb_in[1]  = in_sb;
      vld_in[1] = in_valid;
      for (int j = 2; j <= RW; j++) begin
         l_in[j]   = lane_step(l_ff[j-1], RW - j);
         sb_in[j]  = sb_ff[j-1];
         vld_in[j] = vld_ff[j-1];
      end
      // The leftover exceeds the root exactly when the next half step is passed.
      rd_in.root = l_ff[RW].root;
      rd_in.inc  = l_ff[RW].rem > TW'(l_ff[RW].root);
      sum        = (RW + 1)'(rd_ff.root) + (RW + 1)'(rd_ff.inc);
      ovf_in     = |sum[RW:OW];
      root_in    = ovf_in ? '1 : sum[OW-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff  <= '0;
         rvld_ff <= 1'b0;
         ovld_ff <= 1'b0;
      end else if (en) begin
         vld_ff  <= vld_in;
         rvld_ff <= vld_ff[RW];
         ovld_ff <= rvld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 1; j <= RW; j++) begin
            l_ff[j]  <= l_in[j];
            sb_ff[j] <= sb_in[j];
         end
         rd_ff   <= rd_in;
         rsb_ff  <= sb_ff[RW];
         root_ff <= root_in;
         ovf_ff  <= ovf_in;
         osb_ff  <= rsb_ff;
      end
   end

   assign out_valid = ovld_ff;
   assign out_root  = root_ff;
   assign out_ovf   = ovf_ff;
   assign out_sb    = osb_ff;

`ifndef ASSERT_OFF
   // The leftover of a floor root never exceeds twice the root.
   property p_rem_bound;
      @(posedge clock) disable iff (reset)
         vld_ff[RW] |-> l_ff[RW].rem <= (TW'(l_ff[RW].root) << 1);
   endproperty
   a_rem_bound: assert property (p_rem_bound)
      else $error("square root leftover out of bound");
`endif

endmodule

// ----- design/circumcircle_from_three_points.sv -----
// Top level of the circumcircle pipeline: determinant terms, divider, radius root.
//
//   channel  direction  ports                             carries
//   req      in         req_valid, req_ready, req_data    three points, Q16.16
//   rsp      out        rsp_valid, rsp_ready, rsp_data    center, radius, flags
//
// One triple enters per cycle while the output is not stalled.
// Most of the pipeline depth lies in the two bit-per-stage chains: the divider and the root.
// Reset clears only the valid bits; the data stages are left as they are.
// A stalled output freezes every stage at once, so req_ready falls with it.
module circumcircle_from_three_points (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  circ_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output circ_pkg::rsp_type rsp_data
);

   localparam int W    = circ_pkg::COORD_WIDTH;
   localparam int DW   = W + 1;
   localparam int PW   = 2 * W + 2;
   localparam int EW   = 2 * W + 3;
   localparam int GW   = 2 * W + 4;
   localparam int H    = W + 1;
   localparam int HW   = W + 2;
   localparam int LPW  = DW + HW;
   localparam int DFW  = LPW + 1;
   localparam int NUMW = 3 * W + 5;
   localparam int SW   = 2 * W + 2;
   localparam int RW   = W + 1;
   localparam int DSBW = 2 * W + 1;
   localparam int QSBW = 2 * W + 2;

   typedef struct packed {
      logic signed [DW-1:0] a, b, c, d, sx12, sy12, sx13, sy13, u, v;
      logic signed [W-1:0]  x1, y1;
   } st1_type;

   typedef struct packed {
      logic signed [PW-1:0] m1, m2, m3, m4, m5, m6;
      logic signed [DW-1:0] a, b, c, d;
      logic signed [W-1:0]  x1, y1;
   } st2_type;

   typedef struct packed {
      logic signed [EW-1:0] e, f;
      logic signed [GW-1:0] g;
      logic signed [DW-1:0] a, b, c, d;
      logic signed [W-1:0]  x1, y1;
   } st3_type;

   typedef struct packed {
      logic signed [LPW-1:0] de_lo, de_hi, bf_lo, bf_hi, af_lo, af_hi, ce_lo, ce_hi;
      logic signed [GW-1:0]  g;
      logic signed [W-1:0]   x1, y1;
   } st4_type;

   typedef struct packed {
      logic signed [DFW-1:0] hx, lx, hy, ly;
      logic signed [GW-1:0]  g;
      logic signed [W-1:0]   x1, y1;
   } st5_type;

   typedef struct packed {
      logic signed [NUMW-1:0] nx, ny;
      logic signed [GW-1:0]   g;
      logic signed [W-1:0]    x1, y1;
   } st6_type;

   typedef struct packed {
      logic [NUMW-1:0]     nxa, nya;
      logic [GW-1:0]       ga;
      logic                negx, negy, col;
      logic signed [W-1:0] x1, y1;
   } st7_type;

   typedef struct packed {
      logic signed [DW-1:0] dx, dy;
      logic signed [W-1:0]  cx, cy;
      logic                 ovf, col;
   } st8_type;

   typedef struct packed {
      logic [SW-1:0]       sqx, sqy;
      logic signed [W-1:0] cx, cy;
      logic                ovf, col;
   } st9_type;

   typedef struct packed {
      logic [SW-1:0]       s;
      logic signed [W-1:0] cx, cy;
      logic                ovf, col;
   } st10_type;

   logic     en;
   st1_type  st1_in, st1_ff;
   st2_type  st2_in, st2_ff;
   st3_type  st3_in, st3_ff;
   st4_type  st4_in, st4_ff;
   st5_type  st5_in, st5_ff;
   st6_type  st6_in, st6_ff;
   st7_type  st7_in, st7_ff;
   st8_type  st8_in, st8_ff;
   st9_type  st9_in, st9_ff;
   st10_type st10_in, st10_ff;
   logic [10:1] vld_ff;

   logic                dv_valid;
   logic signed [W-1:0] dv_q0, dv_q1;
   logic                dv_ovf0, dv_ovf1;
   logic [DSBW-1:0]     dv_sb;
   logic                dv_col;
   logic signed [W-1:0] dv_x1, dv_y1;

   logic                sq_valid;
   logic [W-1:0]        sq_root;
   logic                sq_ovf;
   logic [QSBW-1:0]     sq_sb;
   logic signed [W-1:0] sq_cx, sq_cy;
   logic                sq_cov, sq_col;

   circ_pkg::rsp_type rsp_in, rsp_ff;
   logic              rsp_valid_ff;

   logic signed [HW-1:0] e_lo, e_hi, f_lo, f_hi;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   always_comb begin
      st1_in.a    = DW'(req_data.x2) - DW'(req_data.x1);
      st1_in.b    = DW'(req_data.y2) - DW'(req_data.y1);
      st1_in.c    = DW'(req_data.x3) - DW'(req_data.x1);
      st1_in.d    = DW'(req_data.y3) - DW'(req_data.y1);
      st1_in.sx12 = DW'(req_data.x1) + DW'(req_data.x2);
      st1_in.sy12 = DW'(req_data.y1) + DW'(req_data.y2);
      st1_in.sx13 = DW'(req_data.x1) + DW'(req_data.x3);
      st1_in.sy13 = DW'(req_data.y1) + DW'(req_data.y3);
      st1_in.u    = DW'(req_data.y3) - DW'(req_data.y2);
      st1_in.v    = DW'(req_data.x3) - DW'(req_data.x2);
      st1_in.x1   = req_data.x1;
      st1_in.y1   = req_data.y1;

      st2_in.m1 = PW'(st1_ff.a) * PW'(st1_ff.sx12);
      st2_in.m2 = PW'(st1_ff.b) * PW'(st1_ff.sy12);
      st2_in.m3 = PW'(st1_ff.c) * PW'(st1_ff.sx13);
      st2_in.m4 = PW'(st1_ff.d) * PW'(st1_ff.sy13);
      st2_in.m5 = PW'(st1_ff.a) * PW'(st1_ff.u);
      st2_in.m6 = PW'(st1_ff.b) * PW'(st1_ff.v);
      st2_in.a  = st1_ff.a;
      st2_in.b  = st1_ff.b;
      st2_in.c  = st1_ff.c;
      st2_in.d  = st1_ff.d;
      st2_in.x1 = st1_ff.x1;
      st2_in.y1 = st1_ff.y1;

      st3_in.e  = EW'(st2_ff.m1) + EW'(st2_ff.m2);
      st3_in.f  = EW'(st2_ff.m3) + EW'(st2_ff.m4);
      st3_in.g  = (GW'(st2_ff.m5) - GW'(st2_ff.m6)) <<< 1;
      st3_in.a  = st2_ff.a;
      st3_in.b  = st2_ff.b;
      st3_in.c  = st2_ff.c;
      st3_in.d  = st2_ff.d;
      st3_in.x1 = st2_ff.x1;
      st3_in.y1 = st2_ff.y1;

      // The wide sums e and f are split into a signed upper half and an unsigned lower half.
      e_lo = $signed({1'b0, st3_ff.e[H-1:0]});
      e_hi = $signed(st3_ff.e[EW-1:H]);
      f_lo = $signed({1'b0, st3_ff.f[H-1:0]});
      f_hi = $signed(st3_ff.f[EW-1:H]);
      st4_in.de_lo = LPW'(st3_ff.d) * LPW'(e_lo);
      st4_in.de_hi = LPW'(st3_ff.d) * LPW'(e_hi);
      st4_in.bf_lo = LPW'(st3_ff.b) * LPW'(f_lo);
      st4_in.bf_hi = LPW'(st3_ff.b) * LPW'(f_hi);
      st4_in.af_lo = LPW'(st3_ff.a) * LPW'(f_lo);
      st4_in.af_hi = LPW'(st3_ff.a) * LPW'(f_hi);
      st4_in.ce_lo = LPW'(st3_ff.c) * LPW'(e_lo);
      st4_in.ce_hi = LPW'(st3_ff.c) * LPW'(e_hi);
      st4_in.g     = st3_ff.g;
      st4_in.x1    = st3_ff.x1;
      st4_in.y1    = st3_ff.y1;

      st5_in.hx = DFW'(st4_ff.de_hi) - DFW'(st4_ff.bf_hi);
      st5_in.lx = DFW'(st4_ff.de_lo) - DFW'(st4_ff.bf_lo);
      st5_in.hy = DFW'(st4_ff.af_hi) - DFW'(st4_ff.ce_hi);
      st5_in.ly = DFW'(st4_ff.af_lo) - DFW'(st4_ff.ce_lo);
      st5_in.g  = st4_ff.g;
      st5_in.x1 = st4_ff.x1;
      st5_in.y1 = st4_ff.y1;

      st6_in.nx = (NUMW'(st5_ff.hx) <<< H) + NUMW'(st5_ff.lx);
      st6_in.ny = (NUMW'(st5_ff.hy) <<< H) + NUMW'(st5_ff.ly);
      st6_in.g  = st5_ff.g;
      st6_in.x1 = st5_ff.x1;
      st6_in.y1 = st5_ff.y1;

      st7_in.nxa  = st6_ff.nx[NUMW-1] ? NUMW'(-st6_ff.nx) : NUMW'(st6_ff.nx);
      st7_in.nya  = st6_ff.ny[NUMW-1] ? NUMW'(-st6_ff.ny) : NUMW'(st6_ff.ny);
      st7_in.ga   = st6_ff.g[GW-1] ? GW'(-st6_ff.g) : GW'(st6_ff.g);
      st7_in.negx = st6_ff.nx[NUMW-1] ^ st6_ff.g[GW-1];
      st7_in.negy = st6_ff.ny[NUMW-1] ^ st6_ff.g[GW-1];
      st7_in.col  = (st6_ff.g == '0);
      st7_in.x1   = st6_ff.x1;
      st7_in.y1   = st6_ff.y1;
   end

   circ_div #(
      .NW  (NUMW),
      .DNW (GW),
      .QW  (W),
      .SBW (DSBW)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[7]),
      .in_den    (st7_ff.ga),
      .in_num0   (st7_ff.nxa),
      .in_num1   (st7_ff.nya),
      .in_neg0   (st7_ff.negx),
      .in_neg1   (st7_ff.negy),
      .in_sb     ({st7_ff.col, st7_ff.x1, st7_ff.y1}),
      .out_valid (dv_valid),
      .out_q0    (dv_q0),
      .out_q1    (dv_q1),
      .out_ovf0  (dv_ovf0),
      .out_ovf1  (dv_ovf1),
      .out_sb    (dv_sb)
   );

   assign dv_col = dv_sb[DSBW-1];
   assign dv_x1  = $signed(dv_sb[2*W-1:W]);
   assign dv_y1  = $signed(dv_sb[W-1:0]);

   always_comb begin
      st8_in.dx  = DW'(dv_q0) - DW'(dv_x1);
      st8_in.dy  = DW'(dv_q1) - DW'(dv_y1);
      st8_in.cx  = dv_q0;
      st8_in.cy  = dv_q1;
      st8_in.ovf = dv_ovf0 || dv_ovf1;
      st8_in.col = dv_col;

      st9_in.sqx = SW'(PW'(st8_ff.dx) * PW'(st8_ff.dx));
      st9_in.sqy = SW'(PW'(st8_ff.dy) * PW'(st8_ff.dy));
      st9_in.cx  = st8_ff.cx;
      st9_in.cy  = st8_ff.cy;
      st9_in.ovf = st8_ff.ovf;
      st9_in.col = st8_ff.col;

      st10_in.s   = st9_ff.sqx + st9_ff.sqy;
      st10_in.cx  = st9_ff.cx;
      st10_in.cy  = st9_ff.cy;
      st10_in.ovf = st9_ff.ovf;
      st10_in.col = st9_ff.col;
   end

   circ_sqrt #(
      .SW  (SW),
      .RW  (RW),
      .OW  (W),
      .SBW (QSBW)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (vld_ff[10]),
      .in_sq     (st10_ff.s),
      .in_sb     ({st10_ff.cx, st10_ff.cy, st10_ff.ovf, st10_ff.col}),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_ovf   (sq_ovf),
      .out_sb    (sq_sb)
   );

   assign sq_cx  = $signed(sq_sb[QSBW-1:W+2]);
   assign sq_cy  = $signed(sq_sb[W+1:2]);
   assign sq_cov = sq_sb[1];
   assign sq_col = sq_sb[0];

   // Collinear points win over everything; a saturated center forces the radius to all ones.
   always_comb begin
      rsp_in = '0;
      if (sq_col) begin
         rsp_in.collinear = 1'b1;
      end else if (sq_cov) begin
         rsp_in.center_x = sq_cx;
         rsp_in.center_y = sq_cy;
         rsp_in.radius   = '1;
         rsp_in.overflow = 1'b1;
      end else begin
         rsp_in.center_x = sq_cx;
         rsp_in.center_y = sq_cy;
         rsp_in.radius   = sq_root;
         rsp_in.overflow = sq_ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[9:8], dv_valid, vld_ff[6:1], req_valid};
         rsp_valid_ff <= sq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         st1_ff  <= st1_in;
         st2_ff  <= st2_in;
         st3_ff  <= st3_in;
         st4_ff  <= st4_in;
         st5_ff  <= st5_in;
         st6_ff  <= st6_in;
         st7_ff  <= st7_in;
         st8_ff  <= st8_in;
         st9_ff  <= st9_in;
         st10_ff <= st10_in;
         rsp_ff  <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   property p_collinear_zero;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.collinear |->
            rsp_data.center_x == '0 && rsp_data.center_y == '0 &&
            rsp_data.radius == '0 && !rsp_data.overflow;
   endproperty
   a_collinear_zero: assert property (p_collinear_zero)
      else $error("collinear result carries a nonzero field");

   property p_overflow_radius;
      @(posedge clock) disable iff (reset)
         rsp_valid && rsp_data.overflow |-> rsp_data.radius == '1;
   endproperty
   a_overflow_radius: assert property (p_overflow_radius)
      else $error("saturated result without an all-ones radius");

   property p_stall_blocks_input;
      @(posedge clock) disable iff (reset)
         rsp_valid && !rsp_ready |-> !req_ready;
   endproperty
   a_stall_blocks_input: assert property (p_stall_blocks_input)
      else $error("input taken while the output transfer is stalled");

   property p_reset_empties;
      @(posedge clock) reset |=> !rsp_valid && vld_ff == '0;
   endproperty
   a_reset_empties: assert property (p_reset_empties)
      else $error("pipeline not empty after reset");
`endif

endmodule
